// File: hdl/periodic_timer_table_core_macros.svh
// ----------------------------------------------------------------------------
// periodic_timer_table_core_macros.svh
// Assertion macros for the periodic timer table. Define ASSERT_OFF to drop
// every check.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// check a property at every clock edge outside reset
`define PTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that a condition implies another one in the next cycle
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PTT_ASSERT(lbl, prop, msg)
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Field widths, command and status codes and sequencer states of the
// periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int CMD_W  = 2;
  localparam int TIME_W = 64;
  localparam int SLOT_W = 4;
  localparam int TAG_W  = 32;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE_SCAN,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE,
    ST_REPLY
  } state_t;

endpackage

// File: hdl/ptt_in_if.sv
// ----------------------------------------------------------------------------
// ptt_in_if
// Request channel of the periodic timer table: valid, ready and one command.
// ----------------------------------------------------------------------------
interface ptt_in_if;
  import ptt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] period;
  logic [SLOT_W-1:0] slot_in;
  logic [TAG_W-1:0]  tag_in;

  modport source (output valid, command, now, period, slot_in, tag_in, input ready);
  modport sink (input valid, command, now, period, slot_in, tag_in, output ready);

endinterface

// File: hdl/ptt_out_if.sv
// ----------------------------------------------------------------------------
// ptt_out_if
// Response channel of the periodic timer table: valid, ready and one result.
// ----------------------------------------------------------------------------
interface ptt_out_if;
  import ptt_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot_out;
  logic [TIME_W-1:0] deadline;
  logic [TAG_W-1:0]  tag_out;

  modport source (output valid, status, slot_out, deadline, tag_out, input ready);
  modport sink (input valid, status, slot_out, deadline, tag_out, output ready);

endinterface

// File: hdl/periodic_timer_table_core.sv
// ----------------------------------------------------------------------------
// periodic_timer_table_core
// Fixed table of periodic timers: create, delete and earliest-deadline
// get-next, driven by a small sequencer around one shared add/compare unit.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake          | Payload
// in_req   | in  | valid/ready        | command, now, period, slot_in, tag_in
// out_rsp  | out | valid/ready        | status, slot_out, deadline, tag_out
//
// Delete and rejected requests go straight to the reply step; create scans for the first free
// slot, then writes it. Get-next scans every slot, then fetches and updates the earliest; the search
// reads one deadline a cycle from the deadline RAM and compares it in the shared unit.
// rst_n clears the sequencer, the active mask and the response valid.
// A request is taken while a response waits; a stalled response holds the
// sequencer in its reply step until the response register frees up.
// ----------------------------------------------------------------------------
`include "periodic_timer_table_core_macros.svh"

module periodic_timer_table_core #(
  parameter int MAX_TIMERS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ptt_in_if.sink     in_req,
  ptt_out_if.source  out_rsp
);
  import ptt_pkg::*;

  localparam int AW = $clog2(MAX_TIMERS);
  localparam int CW = $clog2(MAX_TIMERS + 1);

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic [TIME_W-1:0]     period_r, period_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         prev_r, prev_nxt;
  logic [AW-1:0]         best_r, best_nxt;
  logic                  found_r, found_nxt;
  logic [TIME_W-1:0]     best_dl_r, best_dl_nxt;
  logic [MAX_TIMERS-1:0] active_r, active_nxt;

  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [TIME_W-1:0] res_dl_r, res_dl_nxt;
  logic [TAG_W-1:0]  res_tag_r, res_tag_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [TIME_W-1:0] out_dl_r, out_dl_nxt;
  logic [TAG_W-1:0]  out_tag_r, out_tag_nxt;

  logic              in_fire;
  logic [AW-1:0]     cnt_idx;
  logic [AW-1:0]     ram_raddr;
  logic              due_we;
  logic              cre_we;
  logic [TIME_W-1:0] due_rdata;
  logic [TIME_W-1:0] per_rdata;
  logic [TAG_W-1:0]  tag_rdata;
  logic [TIME_W-1:0] alu_a;
  logic [TIME_W-1:0] alu_b;
  logic [TIME_W-1:0] alu_sum;
  logic              alu_lt;

  assign in_req.ready     = (state_r == ST_IDLE);
  assign in_fire          = in_req.valid && in_req.ready;
  assign cnt_idx          = cnt_r[AW-1:0];
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_stat_r;
  assign out_rsp.slot_out = out_slot_r;
  assign out_rsp.deadline = out_dl_r;
  assign out_rsp.tag_out  = out_tag_r;

  ptt_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TIMERS)) u_due_ram (
    .clk   (clk),
    .we    (due_we),
    .waddr (best_r),
    .wdata (alu_sum),
    .raddr (ram_raddr),
    .rdata (due_rdata)
  );

  ptt_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TIMERS)) u_per_ram (
    .clk   (clk),
    .we    (cre_we),
    .waddr (best_r),
    .wdata (period_r),
    .raddr (ram_raddr),
    .rdata (per_rdata)
  );

  ptt_ram #(.WIDTH(TAG_W), .DEPTH(MAX_TIMERS)) u_tag_ram (
    .clk   (clk),
    .we    (cre_we),
    .waddr (best_r),
    .wdata (tag_r),
    .raddr (ram_raddr),
    .rdata (tag_rdata)
  );

  ptt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req.command)
            CMD_CREATE: state_nxt = (in_req.period == '0) ? ST_REPLY : ST_FREE_SCAN;
            CMD_NEXT:   state_nxt = ST_SCAN;
            default:    state_nxt = ST_REPLY;
          endcase
        end
      end
      ST_FREE_SCAN: begin
        if (!active_r[cnt_idx]) begin
          state_nxt = ST_UPDATE;
        end else if (cnt_r == CW'(MAX_TIMERS - 1)) begin
          state_nxt = ST_REPLY;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CW'(MAX_TIMERS)) begin
          state_nxt = found_nxt ? ST_FETCH : ST_REPLY;
        end
      end
      ST_FETCH:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_REPLY;
      ST_REPLY: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    period_nxt    = period_r;
    tag_nxt       = tag_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    best_dl_nxt   = best_dl_r;
    active_nxt    = active_r;
    res_stat_nxt  = res_stat_r;
    res_slot_nxt  = res_slot_r;
    res_dl_nxt    = res_dl_r;
    res_tag_nxt   = res_tag_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_stat_nxt  = out_stat_r;
    out_slot_nxt  = out_slot_r;
    out_dl_nxt    = out_dl_r;
    out_tag_nxt   = out_tag_r;
    ram_raddr     = cnt_idx;
    due_we        = 1'b0;
    cre_we        = 1'b0;
    alu_a         = due_rdata;
    alu_b         = best_dl_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt      = in_req.command;
          now_nxt      = in_req.now;
          period_nxt   = in_req.period;
          tag_nxt      = in_req.tag_in;
          cnt_nxt      = '0;
          found_nxt    = 1'b0;
          res_stat_nxt = STAT_OK;
          res_slot_nxt = '0;
          res_dl_nxt   = '0;
          res_tag_nxt  = '0;
          case (in_req.command)
            CMD_CREATE: begin
              if (in_req.period == '0) begin
                res_stat_nxt = STAT_BAD;
              end
            end
            CMD_DELETE: begin
              if (32'(in_req.slot_in) >= 32'(MAX_TIMERS)) begin
                res_stat_nxt = STAT_BAD;
              end else begin
                active_nxt[AW'(in_req.slot_in)] = 1'b0;
                res_slot_nxt = in_req.slot_in;
              end
            end
            CMD_NEXT: begin
              res_stat_nxt = STAT_OK;
            end
            default: begin
              res_stat_nxt = STAT_BAD;
            end
          endcase
        end
      end
      ST_FREE_SCAN: begin
        if (!active_r[cnt_idx]) begin
          best_nxt = cnt_idx;
        end else if (cnt_r == CW'(MAX_TIMERS - 1)) begin
          res_stat_nxt = STAT_FULL;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_SCAN: begin
        prev_nxt = cnt_idx;
        if (cnt_r != CW'(MAX_TIMERS)) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        // compare the deadline read in the previous cycle
        if (cnt_r != '0 && active_r[prev_r] && (!found_r || alu_lt)) begin
          best_nxt    = prev_r;
          best_dl_nxt = due_rdata;
          found_nxt   = 1'b1;
        end
        if (cnt_r == CW'(MAX_TIMERS) && !found_nxt) begin
          res_stat_nxt = STAT_NONE;
        end
      end
      ST_FETCH: begin
        ram_raddr = best_r;
      end
      ST_UPDATE: begin
        due_we       = 1'b1;
        res_stat_nxt = STAT_OK;
        res_slot_nxt = SLOT_W'(best_r);
        if (cmd_r == CMD_CREATE) begin
          alu_a              = now_r;
          alu_b              = period_r;
          cre_we             = 1'b1;
          active_nxt[best_r] = 1'b1;
          res_dl_nxt         = alu_sum;
          res_tag_nxt        = tag_r;
        end else begin
          alu_a       = best_dl_r;
          alu_b       = per_rdata;
          res_dl_nxt  = best_dl_r;
          res_tag_nxt = tag_rdata;
        end
      end
      ST_REPLY: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_slot_nxt  = res_slot_r;
          out_dl_nxt    = res_dl_r;
          out_tag_nxt   = res_tag_r;
        end
      end
      default: begin
        ram_raddr = cnt_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    now_r      <= now_nxt;
    period_r   <= period_nxt;
    tag_r      <= tag_nxt;
    prev_r     <= prev_nxt;
    best_r     <= best_nxt;
    best_dl_r  <= best_dl_nxt;
    res_stat_r <= res_stat_nxt;
    res_slot_r <= res_slot_nxt;
    res_dl_r   <= res_dl_nxt;
    res_tag_r  <= res_tag_nxt;
    out_stat_r <= out_stat_nxt;
    out_slot_r <= out_slot_nxt;
    out_dl_r   <= out_dl_nxt;
    out_tag_r  <= out_tag_nxt;
  end

  `PTT_ASSERT_NEXT(a_busy_after_request, in_fire, state_r != ST_IDLE, "request accepted but sequencer idle")
  `PTT_ASSERT(a_create_free_slot, (state_r == ST_UPDATE && cmd_r == CMD_CREATE) |-> !active_r[best_r], "create claims an active slot")
  `PTT_ASSERT(a_rsp_from_reply, $rose(out_valid_r) |-> $past(state_r == ST_REPLY), "response raised outside reply step")
  `PTT_ASSERT(a_scan_bound, (state_r == ST_SCAN) |-> (32'(cnt_r) <= 32'(MAX_TIMERS)), "scan counter past table end")

endmodule

// File: hdl/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ptt_alu.sv
// ----------------------------------------------------------------------------
// ptt_alu
// Shared 64-bit unit: wrapping add for deadlines and unsigned less-than
// compare for the earliest-deadline search.
// ----------------------------------------------------------------------------
module ptt_alu (
  input  logic [ptt_pkg::TIME_W-1:0] a,
  input  logic [ptt_pkg::TIME_W-1:0] b,
  output logic [ptt_pkg::TIME_W-1:0] sum,
  output logic                       lt
);
  import ptt_pkg::*;

  assign sum = a + b;
  assign lt  = (a < b);

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic timer table. Requests come from a
// queue that is filled up front: a directed opening, then bursts of creates,
// get-next runs, deletes and malformed requests. A predictor of the slot
// table works out each response when its request is taken. Responses are
// compared in order under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ptt_pkg::*;

  localparam int TIMERS = 16;
  localparam int PHASE_ITEMS = 270;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 500000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] period;
    logic [SLOT_W-1:0] slot_in;
    logic [TAG_W-1:0]  tag_in;
  } timer_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_out;
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag_out;
  } timer_rsp_t;

  typedef struct packed {
    timer_req_t req;
    logic [1:0] phase;
    logic       drain_first;
    logic       hold_rx;
  } req_entry_t;

  logic clk = 1'b0;
  logic rst_n;

  ptt_in_if  in_req();
  ptt_out_if out_rsp();

  periodic_timer_table_core #(.MAX_TIMERS(TIMERS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_rsp(out_rsp.source)
  );

  always #5 clk = ~clk;

  req_entry_t req_backlog[$];
  timer_rsp_t due_rsps[$];

  logic [TIME_W-1:0] tbl_due [TIMERS];
  logic [TIME_W-1:0] tbl_period [TIMERS];
  logic [TAG_W-1:0]  tbl_tag [TIMERS];
  logic [TIMERS-1:0] tbl_active = '0;

  int         fail_count = 0;
  int         cycle_count = 0;
  logic       req_taken = 1'b0;
  logic [1:0] cur_phase = 2'd0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         hold_left = 0;

  logic [1:0] build_phase = 2'd0;
  logic       build_drain = 1'b0;
  logic       build_hold = 1'b0;

  timer_req_t taken_req;
  timer_rsp_t head_rsp;
  req_entry_t nxt;

  function automatic int gap_pct(logic [1:0] phase, bit rx_side);
    case (phase)
      2'd1: return rx_side ? 0 : 73;
      2'd2: return rx_side ? 73 : 0;
      2'd3: return 29;
      default: return 0;
    endcase
  endfunction

  function automatic timer_rsp_t timer_table_apply(timer_req_t r);
    timer_rsp_t rsp;
    int best;
    bit found;
    rsp = '0;
    best = 0;
    found = 1'b0;
    case (r.command)
      CMD_CREATE: begin
        if (r.period == '0) begin
          rsp.status = STAT_BAD;
        end else begin
          for (int i = 0; i < TIMERS; i++) begin
            if (!found && !tbl_active[i]) begin
              found = 1'b1;
              best = i;
            end
          end
          if (found) begin
            tbl_due[best] = r.now + r.period;
            tbl_period[best] = r.period;
            tbl_tag[best] = r.tag_in;
            tbl_active[best] = 1'b1;
            rsp.status = STAT_OK;
            rsp.slot_out = best[SLOT_W-1:0];
            rsp.deadline = tbl_due[best];
            rsp.tag_out = r.tag_in;
          end else begin
            rsp.status = STAT_FULL;
          end
        end
      end
      CMD_DELETE: begin
        if (int'(r.slot_in) >= TIMERS) begin
          rsp.status = STAT_BAD;
        end else begin
          tbl_active[r.slot_in] = 1'b0;
          rsp.status = STAT_OK;
          rsp.slot_out = r.slot_in;
        end
      end
      CMD_NEXT: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (tbl_active[i] && (!found || tbl_due[i] < tbl_due[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          rsp.status = STAT_NONE;
        end else begin
          rsp.status = STAT_OK;
          rsp.slot_out = best[SLOT_W-1:0];
          rsp.deadline = tbl_due[best];
          rsp.tag_out = tbl_tag[best];
          tbl_due[best] = tbl_due[best] + tbl_period[best];
        end
      end
      default: rsp.status = STAT_BAD;
    endcase
    return rsp;
  endfunction

  task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
      fail_count++;
    end
  endtask

  task automatic push_req(logic [CMD_W-1:0] command, logic [TIME_W-1:0] now,
                          logic [TIME_W-1:0] period, logic [SLOT_W-1:0] slot_in,
                          logic [TAG_W-1:0] tag_in);
    req_entry_t e;
    e.req = '{command: command, now: now, period: period, slot_in: slot_in,
              tag_in: tag_in};
    e.phase = build_phase;
    e.drain_first = build_drain;
    e.hold_rx = build_hold;
    build_drain = 1'b0;
    build_hold = 1'b0;
    req_backlog.push_back(e);
  endtask

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return TIME_W'($urandom_range(0, 1000));
    if (pick < 85) return rand64();
    return TIME_MAX - TIME_W'($urandom_range(0, 600));
  endfunction

  function automatic logic [TIME_W-1:0] rand_period();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return TIME_W'($urandom_range(1, 500));
    if (pick < 90) return rand64();
    if (pick < 95) return '0;
    return TIME_MAX;
  endfunction

  task automatic build_stimulus();
    int target;
    int n;
    int pick;
    push_req(CMD_NEXT, rand64(), rand64(), 4'hf, $urandom);
    push_req(CMD_UNUSED, TIME_MAX, TIME_MAX, 4'hf, '1);
    push_req(CMD_CREATE, TIME_MAX, '0, 4'h0, '1);
    push_req(CMD_DELETE, '0, '0, 4'hf, '0);
    push_req(CMD_CREATE, TIME_MAX, TIME_MAX, 4'h0, '1);
    push_req(CMD_CREATE, '0, 64'd1, 4'h0, '0);
    push_req(CMD_CREATE, '0, 64'd1, 4'h0, 32'd1);
    repeat (3) push_req(CMD_NEXT, '0, '0, 4'h0, '0);
    push_req(CMD_DELETE, '0, '0, 4'h1, '0);
    push_req(CMD_DELETE, '0, '0, 4'h2, '0);
    push_req(CMD_DELETE, '0, '0, 4'hf, '0);
    repeat (2) push_req(CMD_NEXT, '0, '0, 4'h0, '0);
    push_req(CMD_CREATE, TIME_MAX, 64'd1, 4'h0, 32'h5a5a_a5a5);
    push_req(CMD_NEXT, TIME_MAX, TIME_MAX, 4'h0, '1);
    push_req(CMD_DELETE, '0, '0, 4'h0, '0);
    push_req(CMD_DELETE, '0, '0, 4'h1, '0);
    push_req(CMD_NEXT, '0, '0, 4'h0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      build_phase = ph[1:0];
      build_drain = (ph != 0);
      build_hold = (ph == 0);
      target = req_backlog.size() + PHASE_ITEMS;
      if (ph == 0) begin
        repeat (TIMERS + 1) push_req(CMD_CREATE, rand_time(), TIME_W'($urandom_range(1, 300)),
                                     4'($urandom), $urandom);
        repeat (8) push_req(CMD_NEXT, rand64(), rand64(), 4'($urandom), $urandom);
      end
      while (req_backlog.size() < target) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          n = $urandom_range(1, TIMERS + 2);
          repeat (n) push_req(CMD_CREATE, rand_time(), rand_period(), 4'($urandom), $urandom);
        end else if (pick < 60) begin
          n = $urandom_range(1, 24);
          repeat (n) push_req(CMD_NEXT, rand64(), rand64(), 4'($urandom), $urandom);
        end else if (pick < 80) begin
          n = $urandom_range(1, TIMERS);
          if ($urandom_range(1) == 0) begin
            for (int s = 0; s < n; s++) push_req(CMD_DELETE, rand64(), rand64(), 4'(s), $urandom);
          end else begin
            repeat (n) push_req(CMD_DELETE, rand64(), rand64(), 4'($urandom), $urandom);
          end
        end else begin
          push_req(2'($urandom_range(0, 3)), rand64(),
                   ($urandom_range(3) == 0) ? '0 : rand64(), 4'($urandom), $urandom);
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_req.valid || req_taken) begin
        if (req_backlog.size() == 0) begin
          in_req.valid <= 1'b0;
        end else begin
          nxt = req_backlog[0];
          if ((nxt.drain_first && due_rsps.size() != 0) ||
              $urandom_range(99) < gap_pct(nxt.phase, 1'b0)) begin
            in_req.valid <= 1'b0;
          end else begin
            void'(req_backlog.pop_front());
            in_req.valid <= 1'b1;
            in_req.command <= nxt.req.command;
            in_req.now <= nxt.req.now;
            in_req.period <= nxt.req.period;
            in_req.slot_in <= nxt.req.slot_in;
            in_req.tag_in <= nxt.req.tag_in;
            cur_phase <= nxt.phase;
            if (nxt.hold_rx) begin
              hold_requests <= hold_requests + 1;
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_rsp.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= HOLD_CYCLES;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= ($urandom_range(99) >= gap_pct(cur_phase, 1'b1));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count = cycle_count + 1;
      if (out_rsp.valid && out_rsp.ready) begin
        if (due_rsps.size() == 0) begin
          $error("unexpected response: status %0d slot %0d", out_rsp.status, out_rsp.slot_out);
          fail_count++;
        end else begin
          head_rsp = due_rsps.pop_front();
          check_field("status", 64'(head_rsp.status), 64'(out_rsp.status));
          check_field("slot_out", 64'(head_rsp.slot_out), 64'(out_rsp.slot_out));
          check_field("deadline", head_rsp.deadline, out_rsp.deadline);
          check_field("tag_out", 64'(head_rsp.tag_out), 64'(out_rsp.tag_out));
        end
      end
      req_taken <= in_req.valid && in_req.ready;
      if (in_req.valid && in_req.ready) begin
        taken_req = '{command: in_req.command, now: in_req.now, period: in_req.period,
                      slot_in: in_req.slot_in, tag_in: in_req.tag_in};
        due_rsps.push_back(timer_table_apply(taken_req));
      end
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.command = CMD_CREATE;
    in_req.now = '0;
    in_req.period = '0;
    in_req.slot_in = '0;
    in_req.tag_in = '0;
    out_rsp.ready = 1'b0;
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (req_backlog.size() != 0 || in_req.valid || due_rsps.size() != 0) begin
      @(posedge clk);
    end
    repeat (4 * TIMERS) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
